// ===== design/credit_release_nop_request_defines.svh =====
// Assertion macros shared by the credit release block.
`ifndef CREDIT_RELEASE_NOP_REQUEST_DEFINES_SVH
`define CREDIT_RELEASE_NOP_REQUEST_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CRNR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CRNR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/crnr_pkg.sv =====
// Shared types, constants and helpers for the credit release block.
package crnr_pkg;

    localparam int NUM_CH       = 3;
    localparam int CH_POSTED    = 0;
    localparam int CH_NONPOSTED = 1;
    localparam int CH_RESPONSE  = 2;

    localparam int THR_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [THR_W-1:0] RELAXED_RESET = 5'd4;
    localparam logic [THR_W-1:0] URGENT_RESET  = 5'd2;

    localparam logic [1:0] CREDIT_MAX = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RELAXED = 2'd0,
        REG_URGENT  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [THR_W-1:0] relaxed;
        logic [THR_W-1:0] urgent;
    } thresh_t;

    // Per-item control fanned out to every lane
    typedef struct packed {
        logic accept;
        logic nop_sent;
        logic nop_pending;
    } lane_ctrl_t;

    // What a lane reports for the item being accepted
    typedef struct packed {
        logic       request;
        logic [1:0] credit_next;
    } lane_stat_t;

    // 00 -> 0, 01/10 -> 1, 11 -> 2
    function automatic logic [1:0] decode_freed(logic [1:0] code);
        logic [1:0] val;
        case (code)
            2'b00:   val = 2'd0;
            2'b01:   val = 2'd1;
            2'b10:   val = 2'd1;
            2'b11:   val = 2'd2;
            default: val = 2'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== design/crnr_lane.sv =====
// One virtual-channel lane: free/advertised counts, releasable credit and NOP test.
module crnr_lane #(
    parameter int BUFFERS_PER_CHANNEL = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  crnr_pkg::lane_ctrl_t ctrl,
    input  crnr_pkg::thresh_t   thr,
    input  logic                rx,
    input  logic [1:0]          freed,
    output crnr_pkg::lane_stat_t stat
);

    localparam int CNT_W = $clog2(BUFFERS_PER_CHANNEL) + 1;
    localparam int CMP_W = CNT_W + crnr_pkg::THR_W;
    localparam logic [CNT_W-1:0] FREE_RESET = CNT_W'(BUFFERS_PER_CHANNEL);

    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] adv_reg, adv_next;
    logic [1:0]       credit_reg, credit_next;

    logic [CNT_W-1:0] with_val, without_val, sel_val, rel_val, field_ext;
    logic [CMP_W-1:0] free_ext, relaxed_ext, urgent_ext;
    logic             above_relaxed, at_urgent, request;

    always_comb
    begin
        field_ext   = CNT_W'(credit_reg);
        without_val = free_reg - adv_reg;
        with_val    = without_val - field_ext;
        sel_val     = ctrl.nop_pending ? with_val : without_val;

        free_ext      = CMP_W'(free_reg);
        relaxed_ext   = CMP_W'(thr.relaxed);
        urgent_ext    = CMP_W'(thr.urgent);
        above_relaxed = free_ext > relaxed_ext;
        at_urgent     = free_ext <= urgent_ext;

        request = (above_relaxed  && sel_val >= CNT_W'(2'd3)) ||
                  (!above_relaxed && sel_val >= CNT_W'(2'd2)) ||
                  (at_urgent      && sel_val != '0);

        // credit field saturates at 3; wrapped differences read as large
        rel_val     = ctrl.nop_sent ? with_val : without_val;
        credit_next = (rel_val > CNT_W'(crnr_pkg::CREDIT_MAX)) ? crnr_pkg::CREDIT_MAX
                                                                : rel_val[1:0];

        adv_next  = adv_reg - CNT_W'(rx) + (ctrl.nop_sent ? field_ext : '0);
        free_next = free_reg - CNT_W'(rx) + CNT_W'(crnr_pkg::decode_freed(freed));

        stat.request     = request;
        stat.credit_next = credit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg   <= FREE_RESET;
            adv_reg    <= '0;
            credit_reg <= '0;
        end
        else if (ctrl.accept)
        begin
            free_reg   <= free_next;
            adv_reg    <= adv_next;
            credit_reg <= credit_next;
        end
    end

endmodule

// ===== design/crnr_merge.sv =====
// Merges lane results: request OR, NOP pending hold and the output register.
module crnr_merge (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        accept,
    input  logic                                        nop_sent,
    input  crnr_pkg::lane_stat_t [crnr_pkg::NUM_CH-1:0] stat,
    input  logic                                        out_stall,
    output logic                                        nop_pending,
    output logic                                        out_valid,
    output logic                                        nop_request,
    output logic [1:0]                                  credit_posted,
    output logic [1:0]                                  credit_response,
    output logic [1:0]                                  credit_nonposted
);

    logic       pending_reg, pending_next;
    logic       valid_reg, valid_next;
    logic       req_reg;
    logic [1:0] cp_reg, cr_reg, cn_reg;
    logic       any_req;

    always_comb
    begin
        any_req = 1'b0;
        for (int c = 0; c < crnr_pkg::NUM_CH; c++)
        begin
            any_req = any_req | stat[c].request;
        end
        pending_next = any_req | (pending_reg & ~nop_sent);

        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            valid_reg   <= 1'b0;
            req_reg     <= 1'b0;
            cp_reg      <= '0;
            cr_reg      <= '0;
            cn_reg      <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                pending_reg <= pending_next;
                req_reg     <= any_req;
                cp_reg      <= stat[crnr_pkg::CH_POSTED].credit_next;
                cr_reg      <= stat[crnr_pkg::CH_RESPONSE].credit_next;
                cn_reg      <= stat[crnr_pkg::CH_NONPOSTED].credit_next;
            end
        end
    end

    assign nop_pending      = pending_reg;
    assign out_valid        = valid_reg;
    assign nop_request      = req_reg;
    assign credit_posted    = cp_reg;
    assign credit_response  = cr_reg;
    assign credit_nonposted = cn_reg;

endmodule

// ===== design/credit_release_nop_request.sv =====
// Top level of the receiver-side credit release and NOP request block.
//
// Credit release for three virtual channels (posted, non-posted, response).
// Each accepted item is one link tick: packet-received flags, freed-buffer
// codes and a NOP-sent flag. Three lanes, one per channel, run side by side
// and keep a free-buffer count and an advertised-credit count, each
// $clog2(BUFFERS_PER_CHANNEL)+1 bits wide and wrapping silently. A lane forms
// the releasable credit (free minus advertised, with and without the last
// offered field), saturates it to 3 and tests it against two free-count
// thresholds; the merge stage ORs the lane requests, holds the NOP pending
// flag until a NOP goes out, and registers the result item. Throughput is
// one item per clock unless stalled; each item produces exactly one result
// item in the next cycle, from the output register. in_stall is high only
// while that register is full and out_stall holds it. Thresholds are written
// through cfg_* (index 0 relaxed, index 1 urgent, others ignored); cfg_ready
// is always high and writes are meant for idle periods only.
`include "credit_release_nop_request_defines.svh"

module credit_release_nop_request #(
    parameter int BUFFERS_PER_CHANNEL = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [crnr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crnr_pkg::THR_W-1:0]        cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              rx_posted,
    input  logic                              rx_nonposted,
    input  logic                              rx_response,
    input  logic [1:0]                        freed_posted,
    input  logic [1:0]                        freed_nonposted,
    input  logic [1:0]                        freed_response,
    input  logic                              nop_sent,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              nop_request,
    output logic [1:0]                        credit_posted,
    output logic [1:0]                        credit_response,
    output logic [1:0]                        credit_nonposted
);

    crnr_pkg::thresh_t                         thr_reg;
    crnr_pkg::lane_ctrl_t                      lane_ctrl;
    crnr_pkg::lane_stat_t [crnr_pkg::NUM_CH-1:0] lane_stat;

    logic                                      in_accept;
    logic                                      nop_pending;
    logic [crnr_pkg::NUM_CH-1:0]               rx_vec;
    logic [crnr_pkg::NUM_CH-1:0][1:0]          freed_vec;
    logic [6:0]                                result_word;

    // Output register accepts a new item whenever it is empty or draining.
    assign in_stall  = out_valid & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.relaxed <= crnr_pkg::RELAXED_RESET;
            thr_reg.urgent  <= crnr_pkg::URGENT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (crnr_pkg::cfg_reg_t'(cfg_index))
                crnr_pkg::REG_RELAXED: thr_reg.relaxed <= cfg_data;
                crnr_pkg::REG_URGENT:  thr_reg.urgent  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lane_ctrl.accept      = in_accept;
        lane_ctrl.nop_sent    = nop_sent;
        lane_ctrl.nop_pending = nop_pending;

        rx_vec[crnr_pkg::CH_POSTED]       = rx_posted;
        rx_vec[crnr_pkg::CH_NONPOSTED]    = rx_nonposted;
        rx_vec[crnr_pkg::CH_RESPONSE]     = rx_response;
        freed_vec[crnr_pkg::CH_POSTED]    = freed_posted;
        freed_vec[crnr_pkg::CH_NONPOSTED] = freed_nonposted;
        freed_vec[crnr_pkg::CH_RESPONSE]  = freed_response;
    end

    // One lane per virtual channel
    for (genvar c = 0; c < crnr_pkg::NUM_CH; c++)
    begin : g_lane
        crnr_lane #(
            .BUFFERS_PER_CHANNEL (BUFFERS_PER_CHANNEL)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .thr   (thr_reg),
            .rx    (rx_vec[c]),
            .freed (freed_vec[c]),
            .stat  (lane_stat[c])
        );
    end

    crnr_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (in_accept),
        .nop_sent         (nop_sent),
        .stat             (lane_stat),
        .out_stall        (out_stall),
        .nop_pending      (nop_pending),
        .out_valid        (out_valid),
        .nop_request      (nop_request),
        .credit_posted    (credit_posted),
        .credit_response  (credit_response),
        .credit_nonposted (credit_nonposted)
    );

    // Whole result payload, for the hold check
    assign result_word = {nop_request, credit_posted, credit_response, credit_nonposted};

    // Every accepted item shows up in the output register next cycle
    `CRNR_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid, "accepted item lost")
    // A shown request must leave the pending flag set
    `CRNR_ASSERT_NOW(a_request_pending, out_valid && nop_request, nop_pending, "pending not set")
    // Result payload only moves when an item is accepted
    `CRNR_ASSERT_NEXT(a_result_hold, !in_accept, $stable(result_word), "result changed")

endmodule
